/* hw/rtl/fir_pkg.sv */
// ----------------------------------------------------------------------------
// fir_pkg
// Shared widths, types and constants of the direct-form FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

    localparam int TAPS        = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int NUM_COEF    = 8;
    localparam int COEF_BITS   = 16;
    localparam int FRAC_BITS   = 15;

    // configuration index wide enough to address past the register list
    localparam int CFG_IDX_BITS = 4;

    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DL_DEPTH   = (TAPS > 1) ? TAPS - 1 : 1;
    localparam int PROD_BITS  = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS   = PROD_BITS + $clog2(TAPS);
    localparam int HALF_TAPS  = (TAPS + 1) / 2;

    typedef logic [SAMPLE_BITS-1:0]             sample_t;
    typedef logic [COEF_BITS-1:0]               coef_t;
    typedef logic [NUM_COEF-1:0][COEF_BITS-1:0] coef_vec_t;
    typedef logic [TAPS-1:0][SAMPLE_BITS-1:0]   tap_vec_t;
    // entry 0 is the most recent sample
    typedef logic [DL_DEPTH-1:0][SAMPLE_BITS-1:0] dl_row_t;

    typedef struct packed {
        logic    en;
        dl_row_t row;
    } dl_wr_t;

endpackage

/* hw/rtl/fir_filter.sv */
// ----------------------------------------------------------------------------
// fir_filter
// Direct-form FIR filter over a stream of signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_*  one signed sample per word in, m_axis_* one filtered word out.
//   cfg_*     coefficient writes, index 0..7 = coef_0..coef_7 (Q1.15);
//             other indexes are ignored. Write only while the stream is idle.
// Throughput: one word per clock while m_axis is not stalled. The delay
//   line lives in a one-row memory that is read every cycle and rewritten
//   as each word leaves the first stage; the row written on the previous
//   edge is forwarded.
// Pipeline: first stage with delay-line read, products, partial sums,
//   round/saturate register, then the word is presented on m_axis.
// Reset: coefficients clear to zero, the delay line reads as zeros until
//   its first write, all pipeline stages empty.
// Stall: each stage holds while the stage after it is full and not moving;
//   up to four words sit in flight, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module fir_filter import fir_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [TDATA_BITS-1:0]   s_axis_tdata,   // [15:0] sample_in
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [TDATA_BITS-1:0]   m_axis_tdata,   // [15:0] sample_out
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  coef_t                   cfg_data
);

    coef_vec_t coef;
    dl_row_t   row;
    dl_wr_t    dl_wr;
    tap_vec_t  taps;
    sample_t   out_sample;
    logic      mac_ready;

    logic      s1_valid_reg;
    sample_t   s1_x_reg;

    assign cfg_ready = 1'b1;

    fir_coef_regs u_coef
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    assign s_axis_tready = !s1_valid_reg || mac_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s1_x_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
    end

    fir_delay_mem u_dl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (dl_wr),
        .row   (row)
    );

    // shift the new sample in as the word moves on to the multipliers
    always_comb
    begin
        dl_wr.en     = s1_valid_reg && mac_ready;
        dl_wr.row[0] = s1_x_reg;
        for (int i = 1; i < DL_DEPTH; i++)
        begin
            dl_wr.row[i] = row[i-1];
        end
        taps[0] = s1_x_reg;
        for (int t = 1; t < TAPS; t++)
        begin
            taps[t] = row[t-1];
        end
    end

    fir_mac u_mac
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (mac_ready),
        .taps      (taps),
        .coef      (coef),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_sample)
    );

    assign m_axis_tdata = TDATA_BITS'(out_sample);

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> s1_valid_reg)
        else $error("accepted word did not reach first stage");

    a_empty_s1_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_axis_tready)
        else $error("empty first stage refused input");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !mac_ready |=> s1_valid_reg && $stable(s1_x_reg))
        else $error("stalled first stage lost its sample");

    a_dl_write_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        dl_wr.en |-> s1_valid_reg && !s_axis_tready == 1'b0)
        else $error("delay line written without a moving word");

endmodule

/* hw/rtl/fir_coef_regs.sv */
// ----------------------------------------------------------------------------
// fir_coef_regs
// Coefficient register bank, written through the configuration channel.
// ----------------------------------------------------------------------------
module fir_coef_regs import fir_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  coef_t                   cfg_data,
    output coef_vec_t               coef
);

    coef_vec_t coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                // indexes past the bank are dropped
                if (cfg_index == CFG_IDX_BITS'(i))
                begin
                    coef_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign coef = coef_reg;

endmodule

/* hw/rtl/fir_delay_mem.sv */
// ----------------------------------------------------------------------------
// fir_delay_mem
// Delay line store: one wide row in a synchronous memory, read every cycle,
// with forwarding of the row written on the previous edge.
// ----------------------------------------------------------------------------
module fir_delay_mem import fir_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  dl_wr_t  wr,
    output dl_row_t row
);

    dl_row_t mem [1];
    dl_row_t rd_row_reg;
    dl_row_t hold_row_reg;
    logic    row_ok_reg;
    logic    rd_ok_reg;
    logic    fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[0] <= wr.row;
        end
        rd_row_reg <= mem[0];
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            hold_row_reg <= wr.row;
        end
    end

    // the row is unwritten after reset and reads as zeros until then
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg <= 1'b0;
            rd_ok_reg  <= 1'b0;
            fwd_reg    <= 1'b0;
        end
        else
        begin
            row_ok_reg <= row_ok_reg | wr.en;
            rd_ok_reg  <= row_ok_reg;
            fwd_reg    <= wr.en;
        end
    end

    // a read on the same edge as a write returns the old row
    assign row = fwd_reg   ? hold_row_reg :
                 rd_ok_reg ? rd_row_reg   : '0;

endmodule

/* hw/rtl/fir_mac.sv */
// ----------------------------------------------------------------------------
// fir_mac
// Multiply, sum, round and saturate pipeline: products, two partial sums,
// then final add with rounding into the output register.
// ----------------------------------------------------------------------------
module fir_mac import fir_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  tap_vec_t  taps,
    input  coef_vec_t coef,
    output logic      out_valid,
    input  logic      out_ready,
    output sample_t   out_data
);

    localparam int RND_BITS = ACC_BITS + 1;
    localparam int SH_BITS  = RND_BITS - FRAC_BITS;
    localparam logic signed [RND_BITS-1:0] ROUND_HALF =
        RND_BITS'(1 << (FRAC_BITS - 1));
    localparam logic signed [SH_BITS-1:0] SAT_MAX =
        SH_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SH_BITS-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [PROD_BITS-1:0] prod_reg [TAPS];
    logic                        p_valid_reg;
    logic signed [ACC_BITS-1:0]  sum_lo_reg;
    logic signed [ACC_BITS-1:0]  sum_hi_reg;
    logic                        q_valid_reg;
    sample_t                     out_data_reg;
    logic                        out_valid_reg;

    logic signed [ACC_BITS-1:0]  sum_lo_next;
    logic signed [ACC_BITS-1:0]  sum_hi_next;
    logic signed [ACC_BITS-1:0]  acc;
    logic signed [RND_BITS-1:0]  rnd;
    logic signed [SH_BITS-1:0]   shifted;
    sample_t                     out_data_next;

    logic out_free;
    logic q_adv;
    logic p_adv;

    assign out_free = !out_valid_reg || out_ready;
    assign q_adv    = !q_valid_reg || out_free;
    assign p_adv    = !p_valid_reg || q_adv;
    assign in_ready = p_adv;

    always_comb
    begin
        sum_lo_next = '0;
        sum_hi_next = '0;
        for (int t = 0; t < TAPS; t++)
        begin
            if (t < HALF_TAPS)
            begin
                sum_lo_next = sum_lo_next + ACC_BITS'(prod_reg[t]);
            end
            else
            begin
                sum_hi_next = sum_hi_next + ACC_BITS'(prod_reg[t]);
            end
        end
    end

    // round half up, floor shift, clamp to the sample range
    always_comb
    begin
        acc     = sum_lo_reg + sum_hi_reg;
        rnd     = RND_BITS'(acc) + ROUND_HALF;
        shifted = SH_BITS'(rnd >>> FRAC_BITS);
        if (shifted > SAT_MAX)
        begin
            out_data_next = SAT_MAX[SAMPLE_BITS-1:0];
        end
        else if (shifted < SAT_MIN)
        begin
            out_data_next = SAT_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            out_data_next = shifted[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_adv)
        begin
            for (int t = 0; t < TAPS; t++)
            begin
                prod_reg[t] <= $signed(coef[t]) * $signed(taps[t]);
            end
        end
        if (q_adv)
        begin
            sum_lo_reg <= sum_lo_next;
            sum_hi_reg <= sum_hi_next;
        end
        if (out_free)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            q_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_adv)
            begin
                p_valid_reg <= in_valid;
            end
            if (q_adv)
            begin
                q_valid_reg <= p_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= q_valid_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* test/fir_filter_test.sv */
// ----------------------------------------------------------------------------
// fir_filter_test
// Streams signed samples through the FIR filter under random back-pressure
// and compares every filtered word against an in-bench direct-form model.
// Coefficient sets (reset, unit, full-scale, random) change while idle.
// ----------------------------------------------------------------------------
module fir_filter_test import fir_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT   = 200000;
    localparam int  DRAIN_CYCLES  = 10;
    localparam int  HOLD_LEN      = 300;
    localparam int  ITEMS_PER_SET = 333;
    localparam longint OUT_MAX    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_MIN    = -OUT_MAX - 1;

    typedef enum int {COEF_FULL, COEF_SMALL, COEF_EXTREME} coef_mix_t;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [TDATA_BITS-1:0]   s_axis_tdata  = '0;   // [15:0] sample_in
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [TDATA_BITS-1:0]   m_axis_tdata;         // [15:0] sample_out
    logic                    cfg_valid     = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index     = '0;
    coef_t                   cfg_data      = '0;

    // model state
    coef_t   tap_coef [NUM_COEF];
    sample_t history  [DL_DEPTH];

    sample_t     pending_samples [$];
    sample_t     expected_out    [$];
    int unsigned send_idle   = 0;
    int unsigned recv_idle   = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    logic        hold_req    = 1'b0;
    int unsigned hold_left   = 0;

    fir_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Direct-form sum, round half up, saturate; then shift the delay line.
    function automatic sample_t filter_sample(sample_t x);
        longint acc;
        longint y;
        acc = longint'($signed(tap_coef[0])) * longint'($signed(x));
        for (int t = 1; t < TAPS; t++)
            acc += longint'($signed(tap_coef[t])) * longint'($signed(history[t-1]));
        y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (y > OUT_MAX)
            y = OUT_MAX;
        if (y < OUT_MIN)
            y = OUT_MIN;
        for (int t = DL_DEPTH - 1; t > 0; t--)
            history[t] = history[t-1];
        if (TAPS > 1)
            history[0] = x;
        return sample_t'(y);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_out.push_back(filter_sample(s_axis_tdata[SAMPLE_BITS-1:0]));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    s_axis_tdata  <= TDATA_BITS'(pending_samples.pop_front());
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_req)
            hold_left <= HOLD_LEN;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        sample_t want;
        sample_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[SAMPLE_BITS-1:0];
                if (expected_out.size() == 0)
                begin
                    $error("unexpected word: sample_out actual %0d", $signed(got));
                    error_count++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (got !== want)
                    begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               $signed(want), $signed(got));
                        error_count++;
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[fir_filter] ERROR");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input coef_t val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < NUM_COEF)
            tap_coef[idx[$clog2(NUM_COEF)-1:0]] = val;
        cfg_valid <= 1'b0;
    endtask

    // all taps, then one write past the register list (must be ignored)
    task automatic load_coefs(input coef_t vals [NUM_COEF]);
        for (int i = 0; i < NUM_COEF; i++)
            write_reg(CFG_IDX_BITS'(i), vals[i]);
        write_reg(CFG_IDX_BITS'(NUM_COEF + $urandom_range(2**CFG_IDX_BITS - NUM_COEF - 1)),
                  coef_t'($urandom));
    endtask

    task automatic load_random_coefs(input coef_mix_t mix);
        coef_t vals [NUM_COEF];
        for (int i = 0; i < NUM_COEF; i++)
        begin
            case (mix)
                COEF_FULL:    vals[i] = coef_t'($urandom);
                COEF_SMALL:   vals[i] = coef_t'(int'($urandom_range(8191)) - 4096);
                COEF_EXTREME: vals[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                default:      vals[i] = '0;
            endcase
        end
        load_coefs(vals);
    endtask

    // all words accepted and answered, pipeline drained
    task automatic wait_idle();
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_repeat(input sample_t x, input int n);
        for (int i = 0; i < n; i++)
            pending_samples.push_back(x);
    endtask

    task automatic run_random(input int unsigned snd_idle, input int unsigned rcv_idle,
                              input coef_mix_t mix, input bit with_hold);
        int unsigned pick;
        send_idle = snd_idle;
        recv_idle = rcv_idle;
        load_random_coefs(mix);
        for (int n = 0; n < ITEMS_PER_SET; n++)
        begin
            pick = $urandom_range(15);
            case (pick)
                0:       pending_samples.push_back(16'sh7fff);
                1:       pending_samples.push_back(16'sh8000);
                2:       pending_samples.push_back('0);
                3:       pending_samples.push_back('1);
                default: pending_samples.push_back(sample_t'($urandom));
            endcase
        end
        if (with_hold)
        begin
            // sender keeps offering while the output is blocked
            @(posedge clk);
            hold_req <= 1'b1;
            @(posedge clk);
            hold_req <= 1'b0;
        end
        wait_idle();
    endtask

    initial
    begin : main
        coef_t vals [NUM_COEF];
        for (int i = 0; i < NUM_COEF; i++)
            tap_coef[i] = '0;
        for (int i = 0; i < DL_DEPTH; i++)
            history[i] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients: everything filters to zero
        send_idle = 20;
        recv_idle = 20;
        pending_samples.push_back(16'sh7fff);
        pending_samples.push_back(16'sh8000);
        pending_samples.push_back(16'sh0001);
        wait_idle();

        // unit tap 0 = 1 lsb: rounding at exactly +/- one half
        for (int i = 0; i < NUM_COEF; i++)
            vals[i] = '0;
        vals[0] = 16'sh0001;
        load_coefs(vals);
        pending_samples.push_back(16'sh4000);
        pending_samples.push_back(16'shc000);
        pending_samples.push_back(16'sh3fff);
        wait_idle();

        // full-scale positive taps: saturation both ways
        for (int i = 0; i < NUM_COEF; i++)
            vals[i] = 16'sh7fff;
        load_coefs(vals);
        push_repeat(16'sh7fff, 4);
        push_repeat(16'sh8000, 4);
        wait_idle();

        // most negative taps, including -1.0 * -1.0
        for (int i = 0; i < NUM_COEF; i++)
            vals[i] = 16'sh8000;
        load_coefs(vals);
        push_repeat(16'sh8000, 4);
        push_repeat(16'sh7fff, 4);
        wait_idle();

        run_random(20, 82, COEF_FULL, 1'b1);
        run_random(20, 82, COEF_SMALL, 1'b0);
        run_random(82, 20, COEF_SMALL, 1'b0);
        run_random(82, 20, COEF_FULL, 1'b0);
        run_random(0, 0, COEF_EXTREME, 1'b0);
        run_random(0, 0, COEF_SMALL, 1'b0);

        if (error_count == 0)
            $display("[fir_filter] OK");
        else
            $display("[fir_filter] ERROR");
        $finish;
    end

endmodule
